[design/omkmp_pkg.sv]
// omkmp_pkg: shared types and constants for the ordered multi-pattern matcher
// operation codes, cell control and neighbor link structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package omkmp_pkg;

  localparam int PATTERN_CELLS = 64;
  localparam int GROUP_SLOTS   = 16;
  localparam int VALUE_WIDTH   = 32;
  localparam int GROUP_W       = $clog2(GROUP_SLOTS + 1);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_TEXT  = 2'd2,
    OP_IDLE  = 2'd3
  } op_code_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic                   clear;
    logic                   load;
    logic                   text;
    logic                   advance;
    logic                   last;
    logic [VALUE_WIDTH-1:0] data;
  } cell_ctrl_t;

  // what one cell hands to the next one down the chain
  typedef struct packed {
    logic valid;
    logic mark;
    logic act;
    logic done;
    logic head;
  } cell_link_t;

endpackage

`default_nettype wire

[design/omkmp_if.sv]
// omkmp_in_if / omkmp_out_if: valid-ready channels of the matcher
// the groups_matched width GROUP_W comes from omkmp_pkg; the other payload widths are fixed here
`timescale 1ns / 1ps
`default_nettype none

interface omkmp_in_if
  import omkmp_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] value;
  logic               group_last;

  modport source (output valid, operation, value, group_last, input ready);
  modport sink (input valid, operation, value, group_last, output ready);
endinterface

interface omkmp_out_if
  import omkmp_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic               all_found;
  logic [GROUP_W-1:0] groups_matched;
  logic               overflow;

  modport source (output valid, all_found, groups_matched, overflow, input ready);
  modport sink (input valid, all_found, groups_matched, overflow, output ready);
endinterface

`default_nettype wire

[design/omkmp_cell.sv]
// omkmp_cell: one pattern position of the matcher chain
// holds an element, its group end mark, a partial match bit and the group token
// depends on omkmp_pkg
`timescale 1ns / 1ps
`default_nettype none

module omkmp_cell
  import omkmp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_ctrl_t ctrl,
  input  wire cell_link_t prev,
  output cell_link_t      link,
  output logic            done,
  output logic            tail_opens
);

  logic                   valid_r, valid_nxt;
  logic                   act_r, act_nxt;
  logic                   token_r, token_nxt;
  logic                   mark_r;
  logic [VALUE_WIDTH-1:0] data_r;
  logic                   tail;
  logic                   hit;

  // first empty cell takes the next load
  assign tail       = prev.valid & ~valid_r;
  assign tail_opens = tail & prev.mark;

  // prefix ending here matches if the group starts here or the prefix one shorter matched
  assign hit  = valid_r & (data_r == ctrl.data) & (token_r | (prev.act & ~prev.mark));
  assign done = hit & mark_r;

  always_comb begin
    valid_nxt = valid_r;
    act_nxt   = act_r;
    token_nxt = token_r;
    if (ctrl.clear) begin
      valid_nxt = 1'b0;
      act_nxt   = 1'b0;
      token_nxt = prev.head;
    end else if (ctrl.text) begin
      act_nxt = hit & ~ctrl.advance;
      if (ctrl.advance) begin
        token_nxt = prev.done;
      end
    end else if (ctrl.load && tail) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      act_r   <= 1'b0;
      token_r <= prev.head;
    end else begin
      valid_r <= valid_nxt;
      act_r   <= act_nxt;
      token_r <= token_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!ctrl.clear && ctrl.load && tail) begin
      data_r <= ctrl.data;
      mark_r <= ctrl.last;
    end
  end

  assign link.valid = valid_r;
  assign link.mark  = mark_r;
  assign link.act   = act_r;
  assign link.done  = done;
  assign link.head  = 1'b0;

endmodule

`default_nettype wire

[design/ordered_multi_pattern_kmp_matcher.sv]
// ordered_multi_pattern_kmp_matcher: top level, control counters and the cell chain
// depends on omkmp_pkg, omkmp_if and omkmp_cell
`timescale 1ns / 1ps
`default_nettype none

// One item is taken per clock: every item, whether clear, pattern load or text,
// finishes in the cycle it is accepted, and its status item is held in the output
// register until taken. A text element is compared against all 64 pattern cells at
// once; each cell keeps one bit saying whether the prefix of the group being searched
// that ends at that cell matches the recent text, so every failure fallback of the
// search is resolved in that single compare. in_chan.ready is low only while a status
// item waits and out_chan.ready is low. Loads fill the chain from the front; loads
// past 64 elements or 16 groups are dropped and set the sticky overflow flag.
module ordered_multi_pattern_kmp_matcher
  import omkmp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  omkmp_in_if.sink   in_chan,
  omkmp_out_if.source out_chan
);

  logic               accept;
  logic               out_valid_r, out_valid_nxt;
  logic [GROUP_W-1:0] cur_r, cur_nxt;
  logic [GROUP_W-1:0] grp_r, grp_nxt;
  logic               ovf_r, ovf_nxt;
  logic               search_en;
  logic               is_clear, is_load, is_text;
  logic               full, grp_full, load_ok;
  logic               any_done, any_opens;
  cell_ctrl_t         ctrl;
  cell_link_t         links [PATTERN_CELLS+1];
  logic [PATTERN_CELLS-1:0] done_v;
  logic [PATTERN_CELLS-1:0] opens_v;

  assign in_chan.ready = ~out_valid_r | out_chan.ready;
  assign accept        = in_chan.valid & in_chan.ready;

  assign is_clear = accept & (in_chan.operation == OP_CLEAR);
  assign is_load  = accept & (in_chan.operation == OP_LOAD);
  assign is_text  = accept & (in_chan.operation == OP_TEXT);

  assign search_en = cur_r < grp_r;
  assign full      = links[PATTERN_CELLS].valid;
  assign grp_full  = grp_r >= GROUP_W'(GROUP_SLOTS);
  assign any_done  = |done_v;
  assign any_opens = |opens_v;
  assign load_ok   = is_load & ~full & ~(any_opens & grp_full);

  assign ctrl.clear   = is_clear;
  assign ctrl.load    = load_ok;
  assign ctrl.text    = is_text & search_en;
  assign ctrl.advance = is_text & search_en & any_done;
  assign ctrl.last    = in_chan.group_last;
  assign ctrl.data    = in_chan.value[VALUE_WIDTH-1:0];

  // tie-off in front of cell 0: a closed empty group, token home
  assign links[0].valid = 1'b1;
  assign links[0].mark  = 1'b1;
  assign links[0].act   = 1'b0;
  assign links[0].done  = 1'b0;
  assign links[0].head  = 1'b1;

  for (genvar i = 0; i < PATTERN_CELLS; i++) begin : g_cell
    omkmp_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev       (links[i]),
      .link       (links[i+1]),
      .done       (done_v[i]),
      .tail_opens (opens_v[i])
    );
  end

  always_comb begin
    cur_nxt       = cur_r;
    grp_nxt       = grp_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    if (out_chan.valid && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
    end
    if (is_clear) begin
      cur_nxt = '0;
      grp_nxt = '0;
      ovf_nxt = 1'b0;
    end else begin
      if (ctrl.advance) begin
        cur_nxt = cur_r + GROUP_W'(1);
      end
      if (load_ok && in_chan.group_last) begin
        grp_nxt = grp_r + GROUP_W'(1);
      end
      if (is_load && !load_ok) begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cur_r       <= '0;
      grp_r       <= '0;
      ovf_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
      grp_r       <= grp_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  // status registers only move on accept, so they stand as the held result
  assign out_chan.valid          = out_valid_r;
  assign out_chan.all_found      = ~search_en;
  assign out_chan.groups_matched = cur_r;
  assign out_chan.overflow       = ovf_r;

endmodule

`default_nettype wire

[design/omkmp_checker.sv]
// omkmp_checker: port-level assertions for the matcher, bound to the top level
// depends on omkmp_pkg and ordered_multi_pattern_kmp_matcher
`timescale 1ns / 1ps
`default_nettype none

module omkmp_checker
  import omkmp_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic [1:0]         in_operation,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_all_found,
  input wire logic [GROUP_W-1:0] out_groups_matched,
  input wire logic               out_overflow
);

  logic in_acc;
  assign in_acc = in_valid & in_ready;

  // held result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before it was taken");

  // a clear reports a fresh status
  a_clear_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_operation == OP_CLEAR |=>
      out_valid && out_all_found && out_groups_matched == '0 && !out_overflow)
    else $error("clear did not return status to reset");

  // overflow only leaves on a clear
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_overflow && !(in_acc && in_operation == OP_CLEAR) |=> out_overflow)
    else $error("overflow flag fell without a clear");

  // progress moves only on text or clear
  a_progress: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && (in_operation == OP_TEXT || in_operation == OP_CLEAR)) |=>
      $stable(out_groups_matched))
    else $error("groups matched moved without a text item");

endmodule

bind ordered_multi_pattern_kmp_matcher omkmp_checker u_omkmp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_chan.valid),
  .in_ready           (in_chan.ready),
  .in_operation       (in_chan.operation),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_all_found      (out_chan.all_found),
  .out_groups_matched (out_chan.groups_matched),
  .out_overflow       (out_chan.overflow)
);

`default_nettype wire
